[design/state_blob_validator_assert.svh]
// assertion macros used by the record validator top level
`ifndef STATE_BLOB_VALIDATOR_ASSERT_SVH
`define STATE_BLOB_VALIDATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbv assertion failed");

// next-cycle implication, checked outside reset
`define SBV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbv assertion failed");

`endif

[design/sbv_pkg.sv]
// types, layout constants and helper functions of the record validator
package sbv_pkg;

  localparam int CNT_W     = 11;
  localparam int CRED_LEN  = 128;
  localparam int CLAIM_LEN = 43;
  localparam int BLOB_LEN  = 184;

  localparam logic [CNT_W-1:0] HDR_LEN         = CNT_W'(8);
  localparam logic [CNT_W-1:0] VERSION_OFFSET  = CNT_W'(4);
  localparam logic [CNT_W-1:0] FLAGS_POS       = CNT_W'(5);
  localparam logic [CNT_W-1:0] RSVD_POS        = CNT_W'(6);
  localparam logic [CNT_W-1:0] MAGIC_LEN       = CNT_W'(4);
  localparam logic [CNT_W-1:0] CLAIM_OFF       = CNT_W'(8 + CRED_LEN);
  localparam logic [CNT_W-1:0] CLAIM_END       = CNT_W'(8 + CRED_LEN + CLAIM_LEN);
  localparam logic [CNT_W-1:0] CLAIM_LAST      = CNT_W'(8 + CRED_LEN + CLAIM_LEN - 1);
  localparam logic [CNT_W-1:0] CHK_OFF         = CNT_W'(BLOB_LEN - 4);
  localparam logic [CNT_W-1:0] BLOB_LAST       = CNT_W'(BLOB_LEN - 1);
  localparam logic [CNT_W-1:0] BLOB_END        = CNT_W'(BLOB_LEN);
  localparam logic [CNT_W-1:0] COUNT_MAX       = {CNT_W{1'b1}};

  localparam logic [7:0]  FORMAT_VERSION = 8'h01;
  localparam logic [7:0]  PEND_MASK      = 8'h01;
  localparam logic [1:0]  CLAIM_PAD_MASK = 2'h3;
  localparam logic [31:0] CRC_POLY       = 32'hedb88320;
  localparam logic [31:0] CRC_INIT       = 32'hffffffff;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_LENGTH   = 4'd1,
    ST_MAGIC    = 4'd2,
    ST_VERSION  = 4'd3,
    ST_FLAGS    = 4'd4,
    ST_RESERVED = 4'd5,
    ST_CLAIM    = 4'd6,
    ST_UNUSED   = 4'd7,
    ST_CHECKSUM = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    ROLE_HEADER = 2'd0,
    ROLE_CRED   = 2'd1,
    ROLE_CLAIM  = 2'd2,
    ROLE_TAIL   = 2'd3
  } role_t;

  // outcome of one byte against the current record state
  typedef struct packed {
    role_t       role;
    status_t     err;
    logic        pend;
    logic [31:0] crc;
    logic [31:0] chk;
  } check_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h50;
      2'd1:    r = 8'h57;
      2'd2:    r = 8'h53;
      default: r = 8'h31;
    endcase
    return r;
  endfunction

  // 6-bit base64url value, bit 6 set for a byte outside the alphabet
  function automatic logic [6:0] b64_code(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5a)      v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7a) v = 7'(8'd26 + (c - 8'h61));
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(8'd52 + (c - 8'h30));
    else if (c == 8'h2d)               v = 7'd62;
    else if (c == 8'h5f)               v = 7'd63;
    else                               v = 7'd64;
    return v;
  endfunction

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

[design/sbv_in_stage.sv]
// input register stage of the record validator
module sbv_in_stage import sbv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       advance,
  output logic       in_valid,
  output logic [7:0] in_data,
  output logic       in_last
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

endmodule

[design/sbv_check.sv]
// per-byte checks, crc update and checksum capture
module sbv_check import sbv_pkg::*; (
  input  logic [CNT_W-1:0] pos,
  input  logic [7:0]       data,
  input  logic             last,
  input  logic [31:0]      crc_acc,
  input  logic [31:0]      stored_checksum,
  input  logic             pending_flag,
  output check_t           res
);

  logic [CNT_W-1:0] chk_pos;
  logic [6:0]       b64;

  assign chk_pos = pos - CHK_OFF;
  assign b64     = b64_code(data);

  always_comb begin
    res.role = ROLE_TAIL;
    res.err  = ST_OK;
    res.pend = pending_flag;
    res.crc  = crc_acc;
    res.chk  = stored_checksum;
    if (pos >= BLOB_END) begin
      res.err = ST_LENGTH;
    end else if (pos >= CHK_OFF) begin
      // little-endian checksum, compared when its top byte lands
      res.chk = stored_checksum | ({24'h0, data} << {chk_pos[1:0], 3'b000});
      if (pos == BLOB_LAST && res.chk != ~crc_acc) begin
        res.err = ST_CHECKSUM;
      end
    end else begin
      res.crc = crc_byte(crc_acc, data);
      if (pos < HDR_LEN) begin
        res.role = ROLE_HEADER;
        if (pos < MAGIC_LEN) begin
          if (data != magic_byte(pos[1:0])) res.err = ST_MAGIC;
        end else if (pos == VERSION_OFFSET) begin
          if (data != FORMAT_VERSION) res.err = ST_VERSION;
        end else if (pos == FLAGS_POS) begin
          if ((data & ~PEND_MASK) != 8'h00) res.err = ST_FLAGS;
          res.pend = |(data & PEND_MASK);
        end else if (pos >= RSVD_POS) begin
          if (data != 8'h00) res.err = ST_RESERVED;
        end
      end else if (pos < CLAIM_OFF) begin
        res.role = ROLE_CRED;
      end else begin
        res.role = ROLE_CLAIM;
        if (pending_flag) begin
          if (pos < CLAIM_END) begin
            if (b64[6] || (pos == CLAIM_LAST && (b64[1:0] & CLAIM_PAD_MASK) != 2'b00)) begin
              res.err = ST_CLAIM;
            end
          end
        end else if (data != 8'h00) begin
          res.err = ST_UNUSED;
        end
      end
    end
    // short record
    if (res.err == ST_OK && last && pos < BLOB_LAST) begin
      res.err = ST_LENGTH;
    end
  end

endmodule

[design/state_blob_validator.sv]
// top level of the persisted record validator
// Takes a record one byte per item (s_tdata, s_tlast on the final byte) and
// returns one result item per byte: the byte itself, its role in the layout
// (header, credential, claim area, checksum or excess), the claim-pending
// flag once the flags byte has gone by, and the first error seen so far in
// byte order; on the item with m_tlast set that status is the verdict for
// the whole record. Checks: magic "PWS1", version 1, flags holding only the
// claim-pending bit, zero reserved bytes, base64url claim when pending or an
// all-zero claim area otherwise, exact length, and a reflected crc-32 over
// every byte before the trailing little-endian checksum. Credential bytes are
// only tagged. The block takes one item every cycle while m_tready does not
// stall it: one input register, then byte-wise crc and compare logic feeding
// the result register. After the final byte all state returns to reset, so
// the next byte starts a new record. No clearing pass is needed after reset.
`include "state_blob_validator_assert.svh"

module state_blob_validator import sbv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] pending flag, [12:9] status, rest zero
  output logic [1:0]  m_tuser,   // [1:0] byte_role
  output logic        m_tlast    // done_res
);

  // input register
  logic             in_valid;
  logic [7:0]       in_data;
  logic             in_last;
  logic             advance;

  // record state
  logic [CNT_W-1:0] byte_count;
  logic [31:0]      crc_acc;
  logic [31:0]      stored_checksum;
  status_t          first_error;
  logic             pending_flag;

  check_t           chk;
  status_t          status_next;

  // move an item from the input register into the result register
  assign advance = in_valid && (!m_tvalid || m_tready);

  sbv_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_last  (in_last)
  );

  sbv_check u_check (
    .pos             (byte_count),
    .data            (in_data),
    .last            (in_last),
    .crc_acc         (crc_acc),
    .stored_checksum (stored_checksum),
    .pending_flag    (pending_flag),
    .res             (chk)
  );

  // earliest error wins
  assign status_next = (first_error == ST_OK) ? chk.err : first_error;

  // record state: back to reset after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      crc_acc         <= CRC_INIT;
      stored_checksum <= '0;
      first_error     <= ST_OK;
      pending_flag    <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        byte_count      <= '0;
        crc_acc         <= CRC_INIT;
        stored_checksum <= '0;
        first_error     <= ST_OK;
        pending_flag    <= 1'b0;
      end else begin
        if (byte_count != COUNT_MAX) byte_count <= byte_count + CNT_W'(1);
        crc_acc         <= chk.crc;
        stored_checksum <= chk.chk;
        first_error     <= status_next;
        pending_flag    <= chk.pend;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'b000, status_next, chk.pend, in_data};
      m_tuser <= chk.role;
      m_tlast <= in_last;
    end
  end

  // a finished record leaves the position at zero
  `SBV_ASSERT_NXT(a_count_restart, advance && in_last, byte_count == '0)
  // a recorded error is never replaced within a record
  `SBV_ASSERT_NXT(a_error_sticky, advance && !in_last && first_error != ST_OK,
                  first_error == $past(first_error))
  // the crc stops over the checksum and excess bytes
  `SBV_ASSERT_NXT(a_crc_frozen, advance && !in_last && byte_count >= CHK_OFF,
                  crc_acc == $past(crc_acc))

endmodule
